@@ rtl/gtm_pkg.sv @@
package gtm_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W = 32;
  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_W = 5;
  localparam int GEN_W = 64;
  localparam int CQ_DEPTH = 2;

  localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(16);
  localparam logic [0:0] REG_MAX_QUEUED = 1'b0;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_TAKE = 1'b1;

  localparam logic [2:0] ST_REJECTED = 3'd0;
  localparam logic [2:0] ST_QUEUED = 3'd1;
  localparam logic [2:0] ST_NOTIFY = 3'd2;
  localparam logic [2:0] ST_NO_GEN = 3'd3;
  localparam logic [2:0] ST_STALE = 3'd4;
  localparam logic [2:0] ST_EMPTY = 3'd5;
  localparam logic [2:0] ST_BATCH = 3'd6;

  typedef enum logic [2:0] {
    CMD_REJECT = 3'd0,
    CMD_PUSH = 3'd1,
    CMD_PUSH_FLUSH = 3'd2,
    CMD_NOGEN = 3'd3,
    CMD_STALE = 3'd4,
    CMD_DRAIN = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    logic [CNT_W-1:0] handle;
    logic [CNT_W-1:0] samples;
    logic [CNT_W-1:0] received;
    logic [CNT_W-1:0] malformed;
    logic [CNT_W-1:0] chunks;
    logic [CNT_W-1:0] bytes;
  } entry_t;

  typedef struct packed {
    cmd_kind_t kind;
    entry_t entry;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic [GEN_W-1:0] generation;
    logic [31:0] batch_handle;
    logic [31:0] sample_count;
    logic [31:0] received_bytes;
    logic [31:0] malformed_lines;
    logic [31:0] dropped_chunks;
    logic [31:0] dropped_bytes;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic last;
    logic [31:0] discarded_samples;
    logic [31:0] handle_out;
    logic [31:0] samples_out;
    logic [31:0] received_out;
    logic [31:0] malformed_out;
    logic [31:0] chunks_dropped_out;
    logic [31:0] bytes_dropped_out;
  } rsp_t;

endpackage

@@ rtl/gtm_front.sv @@
module gtm_front import gtm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  input  logic cq_full,
  output logic cq_push,
  output cmd_t cq_cmd
);

  logic [GEN_W-1:0] active_generation;
  logic generation_valid;
  logic accept;

  assign req_stall = cq_full;
  assign accept = req_valid && !cq_full;
  assign cq_push = accept;

  always_comb begin
    cq_cmd.entry.handle = req.batch_handle;
    cq_cmd.entry.samples = req.sample_count;
    cq_cmd.entry.received = req.received_bytes;
    cq_cmd.entry.malformed = req.malformed_lines;
    cq_cmd.entry.chunks = req.dropped_chunks;
    cq_cmd.entry.bytes = req.dropped_bytes;
    if (req.mode == MODE_PUSH) begin
      if (generation_valid && req.generation < active_generation) begin
        cq_cmd.kind = CMD_REJECT;
      end else if (!generation_valid || req.generation > active_generation) begin
        cq_cmd.kind = CMD_PUSH_FLUSH;
      end else begin
        cq_cmd.kind = CMD_PUSH;
      end
    end else begin
      if (!generation_valid) begin
        cq_cmd.kind = CMD_NOGEN;
      end else if (req.generation != active_generation) begin
        cq_cmd.kind = CMD_STALE;
      end else begin
        cq_cmd.kind = CMD_DRAIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_generation <= '0;
      generation_valid <= 1'b0;
    end else if (accept && cq_cmd.kind == CMD_PUSH_FLUSH) begin
      active_generation <= req.generation;
      generation_valid <= 1'b1;
    end
  end

endmodule

@@ rtl/gtm_cmd_fifo.sv @@
module gtm_cmd_fifo import gtm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t rd_cmd
);

  localparam int PW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CW = $clog2(CQ_DEPTH + 1);

  cmd_t slots [CQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CW'(CQ_DEPTH));
  assign nonempty = (count != '0);
  assign rd_cmd = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(CQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(CQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/gtm_back.sv @@
module gtm_back import gtm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic [CFG_W-1:0] max_queued_batches,
  input  logic cq_nonempty,
  input  cmd_t cq_cmd,
  output logic cq_pop,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PUSH = 7'b0000010,
    S_EVICT = 7'b0000100,
    S_REPLY = 7'b0001000,
    S_TAKE = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_DRAIN_RD = 7'b1000000
  } state_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic rsp_t short_rsp(input logic [2:0] st, input logic [CNT_W-1:0] disc);
    rsp_t o;
    o = '0;
    o.status = st;
    o.last = 1'b1;
    o.discarded_samples = disc;
    return o;
  endfunction

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;
  entry_t work;
  state_t state;
  logic [QA_W-1:0] head;
  logic [QA_W-1:0] head_inc;
  logic [QA_W-1:0] slot;
  logic [OCC_W:0] slot_sum;
  logic [OCC_W-1:0] occ;
  logic [OCC_W-1:0] lim;
  logic drain_pending;
  logic [CNT_W-1:0] discard;
  logic [2:0] reply_status;
  logic out_free;
  logic emit;
  logic evict;
  logic we;
  logic re;

  always_comb begin
    if (max_queued_batches == '0) begin
      lim = OCC_W'(1);
    end else if (int'(max_queued_batches) > QUEUE_DEPTH) begin
      lim = OCC_W'(QUEUE_DEPTH);
    end else begin
      lim = OCC_W'(max_queued_batches);
    end
  end

  assign out_free = !rsp_valid || !rsp_stall;
  assign emit = out_free && ((state == S_REPLY) || ((state == S_TAKE) && (occ == '0)) ||
                             (state == S_DRAIN));
  assign evict = (occ >= lim) && (occ != '0);
  assign head_inc = (head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign slot_sum = (OCC_W + 1)'(head) + (OCC_W + 1)'(occ);
  assign slot = (slot_sum >= (OCC_W + 1)'(QUEUE_DEPTH)) ?
                QA_W'(slot_sum - (OCC_W + 1)'(QUEUE_DEPTH)) : QA_W'(slot_sum);
  assign cq_pop = (state == S_IDLE) && cq_nonempty;
  assign we = (state == S_PUSH) && !evict;
  assign re = ((state == S_PUSH) && evict) || ((state == S_TAKE) && (occ != '0)) ||
              (state == S_DRAIN_RD);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[slot] <= work;
    end
    if (re) begin
      rd_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      occ <= '0;
      drain_pending <= 1'b0;
      discard <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= emit || (rsp_valid && rsp_stall);
      case (state)
        S_IDLE: begin
          if (cq_nonempty) begin
            work <= cq_cmd.entry;
            case (cq_cmd.kind)
              CMD_PUSH: begin
                state <= S_PUSH;
              end
              CMD_PUSH_FLUSH: begin
                head <= '0;
                occ <= '0;
                discard <= '0;
                drain_pending <= 1'b0;
                state <= S_PUSH;
              end
              CMD_DRAIN: begin
                state <= S_TAKE;
              end
              CMD_NOGEN: begin
                reply_status <= ST_NO_GEN;
                state <= S_REPLY;
              end
              CMD_STALE: begin
                reply_status <= ST_STALE;
                state <= S_REPLY;
              end
              default: begin
                reply_status <= ST_REJECTED;
                state <= S_REPLY;
              end
            endcase
          end
        end
        S_PUSH: begin
          if (evict) begin
            state <= S_EVICT;
          end else begin
            occ <= occ + 1'b1;
            reply_status <= drain_pending ? ST_QUEUED : ST_NOTIFY;
            drain_pending <= 1'b1;
            state <= S_REPLY;
          end
        end
        S_EVICT: begin
          discard <= sat_add(discard, rd_data.samples);
          work.received <= sat_add(work.received, rd_data.received);
          work.malformed <= sat_add(work.malformed, rd_data.malformed);
          work.chunks <= sat_add(work.chunks, rd_data.chunks);
          work.bytes <= sat_add(work.bytes, rd_data.bytes);
          head <= head_inc;
          occ <= occ - 1'b1;
          state <= S_PUSH;
        end
        S_REPLY: begin
          if (out_free) begin
            rsp <= short_rsp(reply_status, '0);
            state <= S_IDLE;
          end
        end
        S_TAKE: begin
          if (occ != '0) begin
            state <= S_DRAIN;
          end else if (out_free) begin
            rsp <= short_rsp(ST_EMPTY, discard);
            discard <= '0;
            drain_pending <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_DRAIN: begin
          if (out_free) begin
            rsp.status <= ST_BATCH;
            rsp.last <= (occ == OCC_W'(1));
            rsp.discarded_samples <= discard;
            rsp.handle_out <= rd_data.handle;
            rsp.samples_out <= rd_data.samples;
            rsp.received_out <= rd_data.received;
            rsp.malformed_out <= rd_data.malformed;
            rsp.chunks_dropped_out <= rd_data.chunks;
            rsp.bytes_dropped_out <= rd_data.bytes;
            head <= head_inc;
            occ <= occ - 1'b1;
            if (occ == OCC_W'(1)) begin
              discard <= '0;
              drain_pending <= 1'b0;
              state <= S_IDLE;
            end else begin
              state <= S_DRAIN_RD;
            end
          end
        end
        S_DRAIN_RD: begin
          state <= S_DRAIN;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_only_batch_continues: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.status == ST_BATCH)
    else $error("non-final result that is not a batch");

  a_non_batch_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_BATCH |-> rsp.handle_out == '0 && rsp.samples_out == '0)
    else $error("non-batch result carries entry data");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && $past(state) == S_DRAIN |-> occ == '0)
    else $error("drain finished with entries left");

endmodule

@@ rtl/generation_tagged_drop_oldest_mailbox.sv @@
// Push: handled in the push and reply states; each evicted entry adds a read in the push
// state and a pass through the evict state. Take: each batch is read in the take or
// drain-read state and sent from the drain state; the entry memory read is registered.
// Requests are accepted into a two-entry command queue while the back end works.
// Reset is synchronous: the queue empties, the generation is cleared and the limit is 16.
// Entry memory contents are undefined after reset and need no clearing pass.
module generation_tagged_drop_oldest_mailbox import gtm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  logic [CFG_W-1:0] max_queued_batches;
  logic cq_push;
  logic cq_full;
  logic cq_pop;
  logic cq_nonempty;
  cmd_t front_cmd;
  cmd_t back_cmd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_QUEUED) ? 32'(max_queued_batches) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_queued_batches <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MAX_QUEUED) begin
      max_queued_batches <= pwdata[CFG_W-1:0];
    end
  end

  gtm_front u_front (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .cq_full(cq_full),
    .cq_push(cq_push),
    .cq_cmd(front_cmd)
  );

  gtm_cmd_fifo u_cmd_fifo (
    .clk(clk),
    .rst(rst),
    .push(cq_push),
    .wr_cmd(front_cmd),
    .full(cq_full),
    .pop(cq_pop),
    .nonempty(cq_nonempty),
    .rd_cmd(back_cmd)
  );

  gtm_back u_back (
    .clk(clk),
    .rst(rst),
    .max_queued_batches(max_queued_batches),
    .cq_nonempty(cq_nonempty),
    .cq_cmd(back_cmd),
    .cq_pop(cq_pop),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

endmodule

@@ tb/sv/generation_tagged_drop_oldest_mailbox_checker.sv @@
`timescale 1ns / 100ps
module generation_tagged_drop_oldest_mailbox_checker import gtm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  input  logic pready,
  output int outstanding,
  output int mismatches
);

  localparam int DUE_DEPTH = 1024;

  entry_t slots [QUEUE_DEPTH];
  logic [QA_W-1:0] head;
  int occ;
  logic [GEN_W-1:0] active_gen;
  logic gen_known;
  logic notice_sent;
  logic [CNT_W-1:0] discard_sum;
  logic [CFG_W-1:0] queue_limit;
  rsp_t due_rsp [DUE_DEPTH];
  int due_wr;
  int due_rd;

  function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  function automatic rsp_t plain_rsp(input logic [2:0] st, input logic fin,
                                     input logic [31:0] disc);
    rsp_t o;
    o = '0;
    o.status = st;
    o.last = fin;
    o.discarded_samples = disc;
    return o;
  endfunction

  task automatic expect_rsp(input rsp_t o);
    due_rsp[due_wr % DUE_DEPTH] = o;
    due_wr++;
  endtask

  task automatic predict_request(input req_t r);
    int lim;
    entry_t inc;
    rsp_t o;
    lim = int'(queue_limit);
    if (lim == 0) lim = 1;
    if (lim > QUEUE_DEPTH) lim = QUEUE_DEPTH;
    if (r.mode == MODE_PUSH) begin
      if (gen_known && r.generation < active_gen) begin
        expect_rsp(plain_rsp(ST_REJECTED, 1'b1, '0));
        return;
      end
      if (!gen_known || r.generation > active_gen) begin
        occ = 0;
        head = '0;
        discard_sum = '0;
        active_gen = r.generation;
        gen_known = 1'b1;
        notice_sent = 1'b0;
      end
      inc.handle = r.batch_handle;
      inc.samples = r.sample_count;
      inc.received = r.received_bytes;
      inc.malformed = r.malformed_lines;
      inc.chunks = r.dropped_chunks;
      inc.bytes = r.dropped_bytes;
      // Evicted entries fold their traffic counters into the new batch.
      while (occ >= lim && occ > 0) begin
        discard_sum = sat_sum(discard_sum, slots[head].samples);
        inc.received = sat_sum(inc.received, slots[head].received);
        inc.malformed = sat_sum(inc.malformed, slots[head].malformed);
        inc.chunks = sat_sum(inc.chunks, slots[head].chunks);
        inc.bytes = sat_sum(inc.bytes, slots[head].bytes);
        head = QA_W'((int'(head) + 1) % QUEUE_DEPTH);
        occ--;
      end
      slots[(int'(head) + occ) % QUEUE_DEPTH] = inc;
      occ++;
      expect_rsp(plain_rsp(notice_sent ? ST_QUEUED : ST_NOTIFY, 1'b1, '0));
      notice_sent = 1'b1;
    end else if (!gen_known) begin
      expect_rsp(plain_rsp(ST_NO_GEN, 1'b1, '0));
    end else if (r.generation != active_gen) begin
      expect_rsp(plain_rsp(ST_STALE, 1'b1, '0));
    end else begin
      if (occ == 0) begin
        expect_rsp(plain_rsp(ST_EMPTY, 1'b1, discard_sum));
      end
      while (occ > 0) begin
        o = plain_rsp(ST_BATCH, occ == 1, discard_sum);
        o.handle_out = slots[head].handle;
        o.samples_out = slots[head].samples;
        o.received_out = slots[head].received;
        o.malformed_out = slots[head].malformed;
        o.chunks_dropped_out = slots[head].chunks;
        o.bytes_dropped_out = slots[head].bytes;
        expect_rsp(o);
        head = QA_W'((int'(head) + 1) % QUEUE_DEPTH);
        occ--;
      end
      discard_sum = '0;
      notice_sent = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      head = '0;
      occ = 0;
      active_gen = '0;
      gen_known = 1'b0;
      notice_sent = 1'b0;
      discard_sum = '0;
      queue_limit = LIMIT_RESET;
      due_wr = 0;
      due_rd = 0;
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'(4 * REG_MAX_QUEUED)) begin
        queue_limit = pwdata[CFG_W-1:0];
      end
      if (req_valid && !req_stall) predict_request(req);
      if (rsp_valid && !rsp_stall) begin
        if (due_wr == due_rd) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got %h", $time, rsp);
        end else begin
          want = due_rsp[due_rd % DUE_DEPTH];
          due_rd++;
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("last", 32'(want.last), 32'(rsp.last));
          check_field("discarded_samples", want.discarded_samples, rsp.discarded_samples);
          check_field("handle_out", want.handle_out, rsp.handle_out);
          check_field("samples_out", want.samples_out, rsp.samples_out);
          check_field("received_out", want.received_out, rsp.received_out);
          check_field("malformed_out", want.malformed_out, rsp.malformed_out);
          check_field("chunks_dropped_out", want.chunks_dropped_out, rsp.chunks_dropped_out);
          check_field("bytes_dropped_out", want.bytes_dropped_out, rsp.bytes_dropped_out);
        end
      end
    end
    outstanding <= due_wr - due_rd;
  end

endmodule

@@ tb/sv/generation_tagged_drop_oldest_mailbox_test.sv @@
`timescale 1ns / 100ps
module generation_tagged_drop_oldest_mailbox_test;
  import gtm_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_WAIT = 64;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 31;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int outstanding;
  int mismatches;

  bit send_quiet = 1'b0;
  bit take_quiet = 1'b0;
  bit hold_long = 1'b0;
  logic [GEN_W-1:0] cur_gen = '0;
  bit gen_open = 1'b0;

  generation_tagged_drop_oldest_mailbox u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  generation_tagged_drop_oldest_mailbox_checker u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .outstanding(outstanding), .mismatches(mismatches)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("generation_tagged_drop_oldest_mailbox_test: FAIL");
    $finish;
  end

  function automatic int idle_draw(input bit quiet);
    if (quiet) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic logic [31:0] count_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t push_req(input logic [GEN_W-1:0] g);
    req_t r;
    r.mode = MODE_PUSH;
    r.generation = g;
    r.batch_handle = $urandom;
    r.sample_count = count_value();
    r.received_bytes = count_value();
    r.malformed_lines = count_value();
    r.dropped_chunks = count_value();
    r.dropped_bytes = count_value();
    return r;
  endfunction

  function automatic req_t take_req(input logic [GEN_W-1:0] g);
    req_t r;
    r = push_req(g);
    r.mode = MODE_TAKE;
    return r;
  endfunction

  function automatic req_t saturating_push(input logic [GEN_W-1:0] g);
    req_t r;
    r = push_req(g);
    r.sample_count = '1;
    r.received_bytes = '1;
    r.malformed_lines = '1;
    r.dropped_chunks = '1;
    r.dropped_bytes = '1;
    return r;
  endfunction

  // Mostly requests against the live generation, with flushes, rejected
  // pushes and stale takes mixed in.
  function automatic req_t mailbox_traffic();
    int roll;
    logic [GEN_W-1:0] g;
    roll = $urandom_range(0, 99);
    if (roll < 55) return push_req(cur_gen);
    if (roll < 75) return take_req(cur_gen);
    if (roll < 82) begin
      if (cur_gen > 64'hF000_0000_0000_0000) return push_req(cur_gen);
      if (roll % 2 == 0) g = cur_gen + 64'({$urandom_range(0, 255), $urandom}) + 1;
      else g = cur_gen + $urandom_range(1, 16);
      return push_req(g);
    end
    if (roll < 88) begin
      g = (cur_gen > 64'd1000) ? cur_gen - $urandom_range(1, 1000) : '0;
      return push_req(g);
    end
    if (roll < 95) return take_req(cur_gen ^ (64'd1 << $urandom_range(0, 63)));
    return take_req({$urandom, $urandom});
  endfunction

  task automatic send(input req_t r);
    int gap;
    gap = idle_draw(send_quiet);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    if (r.mode == MODE_PUSH && (!gen_open || r.generation > cur_gen)) begin
      cur_gen = r.generation;
      gen_open = 1'b1;
    end
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CFG_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_MAX_QUEUED);
    pwdata <= {27'($urandom_range(0, 32'h07FF_FFFF)), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : receiver
    int left;
    bit held;
    left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long && !held) begin
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (rsp_valid && !rsp_stall) left = idle_draw(take_quiet);
      if (left > 0) begin
        rsp_stall <= 1'b1;
        left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [GEN_W-1:0] g;
    logic [CFG_W-1:0] lim;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send(take_req(64'd0));
    send(push_req(64'd5));
    send(push_req(64'd5));
    send(push_req(64'd4));
    send(take_req(64'd6));
    send(take_req(64'd5));
    send(take_req(64'd5));

    // A limit of one evicts on every push to a nonempty queue, so saturated counters pile up.
    settle();
    set_limit(5'd1);
    g = 64'h0123_4567_89AB_CDEF;
    repeat (3) send(saturating_push(g));
    send(take_req(g));

    settle();
    set_limit(5'd0);
    send(push_req(g));
    send(push_req(g));
    send(take_req(g));

    settle();
    set_limit(5'd16);
    repeat (4) send(push_req(g));
    settle();
    set_limit(5'd2);
    send(push_req(g));
    send(take_req(g));

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: lim = 5'd31;
        1: lim = 5'd2;
        2: lim = 5'd16;
        3: lim = 5'd0;
        4: lim = 5'd3;
        5: lim = 5'd1;
        default: lim = CFG_W'($urandom_range(0, 31));
      endcase
      set_limit(lim);
      send_quiet = (p % 4 == 1);
      take_quiet = (p % 4 == 2);
      if (p == 3) begin
        send_quiet = 1'b1;
        hold_long = 1'b1;
      end
      repeat (PHASE_ITEMS) send(mailbox_traffic());
    end

    send(push_req('1));
    send(take_req('1));
    settle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("generation_tagged_drop_oldest_mailbox_test: PASS");
    end else begin
      $display("generation_tagged_drop_oldest_mailbox_test: FAIL");
    end
    $finish;
  end

endmodule

@@ generation_tagged_drop_oldest_mailbox.f @@
rtl/gtm_pkg.sv
rtl/gtm_front.sv
rtl/gtm_cmd_fifo.sv
rtl/gtm_back.sv
rtl/generation_tagged_drop_oldest_mailbox.sv
tb/sv/generation_tagged_drop_oldest_mailbox_checker.sv
tb/sv/generation_tagged_drop_oldest_mailbox_test.sv
